### hw/rtl/swmf_pkg.sv
// Package for the sliding window median filter.
// Holds the window size, derived widths, request codes and the cell link type.
// No dependencies.
`default_nettype none

package swmf_pkg;

  localparam int WINDOW = 5;
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_RAW_W = $clog2(WINDOW + 1);
  localparam int CNT_W  = (CNT_RAW_W > 3) ? CNT_RAW_W : 3;
  localparam int SMP_W  = 16;
  localparam int VCNT_W = 3;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // What one cell shows to its neighbours.
  typedef struct packed {
    logic signed [SMP_W-1:0] val;
    logic [IDX_W-1:0]        slot;
    logic                    valid;
    logic                    gt;
  } cell_link_t;

endpackage

`default_nettype wire

### hw/rtl/swmf_cell.sv
// One cell of the sorted window chain: holds one sample and its slot tag.
// Depends on swmf_pkg.
`default_nettype none

module swmf_cell
  import swmf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    upd,
  input  wire logic                    clr,
  input  wire logic signed [SMP_W-1:0] x,
  input  wire logic [IDX_W-1:0]        wp,
  input  wire logic                    full,
  input  wire cell_link_t              left,
  input  wire cell_link_t              right,
  input  wire logic                    pl_in,
  output cell_link_t                   me,
  output logic                         pl_out,
  output logic signed [SMP_W-1:0]      val_nxt
);

  logic signed [SMP_W-1:0] val_r;
  logic [IDX_W-1:0]        slot_r, slot_nxt;
  logic                    valid_r, valid_nxt;
  logic                    gt;
  logic                    del;

  // Invalid cells sit at the tail and count as larger than any sample.
  assign gt = !valid_r || (val_r > x);

  // The cell that leaves: the oldest sample once full, else the first empty cell.
  assign del = full ? (valid_r && (slot_r == wp)) : (!valid_r && left.valid);

  assign pl_out = pl_in | del;

  always_comb begin
    val_nxt  = val_r;
    slot_nxt = slot_r;
    if (!pl_in && !del) begin
      if (gt) begin
        if (left.gt) begin
          val_nxt  = left.val;
          slot_nxt = left.slot;
        end else begin
          val_nxt  = x;
          slot_nxt = wp;
        end
      end
    end else if (del) begin
      if (left.gt) begin
        val_nxt  = left.val;
        slot_nxt = left.slot;
      end else if (!right.gt) begin
        val_nxt  = right.val;
        slot_nxt = right.slot;
      end else begin
        val_nxt  = x;
        slot_nxt = wp;
      end
    end else begin
      if (!right.gt) begin
        val_nxt  = right.val;
        slot_nxt = right.slot;
      end else if (!gt) begin
        val_nxt  = x;
        slot_nxt = wp;
      end
    end
  end

  assign valid_nxt = valid_r | (!full && del);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clr) begin
      valid_r <= 1'b0;
    end else if (upd) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      val_r  <= val_nxt;
      slot_r <= slot_nxt;
    end
  end

  assign me.val   = val_r;
  assign me.slot  = slot_r;
  assign me.valid = valid_r;
  assign me.gt    = gt;

endmodule

`default_nettype wire

### hw/rtl/sliding_window_median_filter_core.sv
// Top level of the sliding window median filter: chain of sorted cells and output register.
// Depends on swmf_pkg and swmf_cell.
`default_nettype none

// Each sample item is inserted into a chain of WINDOW cells that keeps the window sorted;
// once the window is full, the oldest sample drops out in the same cycle, so an item is
// taken every clock cycle while in_ready is high and its median appears in the output
// register on the next edge, from the single compare-and-shift step across the cell chain.
// A clear item empties the window and produces no result. in_ready falls only while a
// result waits for out_ready.

module sliding_window_median_filter_core
  import swmf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_req_type,
  input  wire logic signed [SMP_W-1:0]  in_sample,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [SMP_W-1:0]       out_median,
  output logic [VCNT_W-1:0]             out_valid_count
);

  logic                    acc, upd, clr;
  logic [IDX_W-1:0]        wp_r, wp_nxt;
  logic                    full_r, full_nxt;
  logic [CNT_W-1:0]        count_nxt;
  logic [CNT_W-1:0]        mid;
  logic                    out_valid_r;
  logic signed [SMP_W-1:0] median_r;
  logic [VCNT_W-1:0]       vcnt_r;
  logic [WINDOW-1:0]       valid_vec;

  cell_link_t              links [WINDOW];
  logic [WINDOW:0]         pl;
  logic signed [SMP_W-1:0] val_nxt [WINDOW];
  cell_link_t              left_edge, right_edge;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign upd      = acc && (in_req_type == REQ_SAMPLE);
  assign clr      = acc && (in_req_type == REQ_CLEAR);

  // Boundary links: a valid, never-greater cell on the left, an empty one on the right.
  assign left_edge.val    = '0;
  assign left_edge.slot   = '0;
  assign left_edge.valid  = 1'b1;
  assign left_edge.gt     = 1'b0;
  assign right_edge.val   = '0;
  assign right_edge.slot  = '0;
  assign right_edge.valid = 1'b0;
  assign right_edge.gt    = 1'b1;

  assign pl[0] = 1'b0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    swmf_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .upd     (upd),
      .clr     (clr),
      .x       (in_sample),
      .wp      (wp_r),
      .full    (full_r),
      .left    ((i == 0) ? left_edge : links[(i == 0) ? 0 : i - 1]),
      .right   ((i == WINDOW - 1) ? right_edge : links[(i == WINDOW - 1) ? i : i + 1]),
      .pl_in   (pl[i]),
      .me      (links[i]),
      .pl_out  (pl[i+1]),
      .val_nxt (val_nxt[i])
    );
    assign valid_vec[i] = links[i].valid;
  end

  assign wp_nxt    = (wp_r == IDX_W'(WINDOW - 1)) ? '0 : wp_r + 1'b1;
  assign full_nxt  = full_r || (wp_r == IDX_W'(WINDOW - 1));
  assign count_nxt = full_nxt ? CNT_W'(WINDOW) : CNT_W'(wp_nxt);
  assign mid       = count_nxt >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      full_r <= 1'b0;
    end else if (clr) begin
      wp_r   <= '0;
      full_r <= 1'b0;
    end else if (upd) begin
      wp_r   <= wp_nxt;
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      median_r <= val_nxt[mid[IDX_W-1:0]];
      vcnt_r   <= count_nxt[VCNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_median      = median_r;
  assign out_valid_count = vcnt_r;

  // The occupied cells always form a prefix of the chain.
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("occupied cells do not form a prefix");

  a_full_all_valid: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (&valid_vec))
    else $error("window full but some cell is empty");

  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    !full_r |-> ($countones(valid_vec) == int'(wp_r)))
    else $error("fill count disagrees with write position");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> out_valid_r)
    else $error("sample item gave no result");

endmodule

`default_nettype wire

### bench/swmf_median_checker.sv
// Checker for the sliding window median filter: watches both channels, predicts each median
// from its own copy of the window and compares it with what the block returns.
// Depends on swmf_pkg.

module swmf_median_checker
  import swmf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_req_type,
  input  logic signed [SMP_W-1:0] in_sample,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [SMP_W-1:0] out_median,
  input  logic [VCNT_W-1:0]       out_valid_count,
  output int                      err_count,
  output int                      pending,
  output int                      medians_checked
);

  typedef struct packed {
    logic signed [SMP_W-1:0] median;
    logic [VCNT_W-1:0]       count;
  } median_exp_t;

  logic signed [SMP_W-1:0] window_copy [WINDOW];
  int                      next_slot;
  logic                    filled;
  median_exp_t             expected_medians [$];
  int                      mismatches = 0;
  int                      n_checked = 0;

  assign err_count       = mismatches;
  assign medians_checked = n_checked;

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("MISMATCH %s: expected %0d, got %0d (result %0d)", what, want, got, n_checked);
    mismatches++;
  endtask

  // Value at rank n/2 of the first n window entries, by insertion sort.
  function automatic logic signed [SMP_W-1:0] window_median(input int n);
    logic signed [SMP_W-1:0] sorted [WINDOW];
    logic signed [SMP_W-1:0] v;
    int i;
    int j;
    for (i = 0; i < n; i++) begin
      v = window_copy[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    return sorted[n / 2];
  endfunction

  function automatic void empty_window();
    foreach (window_copy[k]) window_copy[k] = '0;
    next_slot = 0;
    filled    = 1'b0;
  endfunction

  always @(posedge clk) begin
    median_exp_t want;
    int          count;
    if (!rst_n) begin
      empty_window();
      expected_medians.delete();
    end else begin
      // Results leave before the item accepted at this edge can have produced one.
      if (out_valid && out_ready) begin
        if (expected_medians.size() == 0) begin
          report_mismatch("result with no median expected", 0, int'(out_median));
        end else begin
          want = expected_medians.pop_front();
          if (out_median !== want.median)
            report_mismatch("median", int'(want.median), int'(out_median));
          if (out_valid_count !== want.count)
            report_mismatch("valid_count", int'(want.count), int'(out_valid_count));
        end
        n_checked++;
      end
      if (in_valid && in_ready) begin
        if (in_req_type == REQ_CLEAR) begin
          empty_window();
        end else begin
          window_copy[next_slot] = in_sample;
          next_slot++;
          if (next_slot >= WINDOW) begin
            next_slot = 0;
            filled    = 1'b1;
          end
          count       = filled ? WINDOW : next_slot;
          want.median = window_median(count);
          want.count  = VCNT_W'(count);
          expected_medians.push_back(want);
        end
      end
    end
    pending <= expected_medians.size();
  end

endmodule

### bench/sliding_window_median_filter_core_tb.sv
// Testbench top for the sliding window median filter core: clock, reset, stimulus and verdict.
// Depends on swmf_pkg, sliding_window_median_filter_core and swmf_median_checker.

module sliding_window_median_filter_core_tb;
  import swmf_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int N_RANDOM    = 700;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_req_type = REQ_SAMPLE;
  logic signed [SMP_W-1:0] in_sample = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SMP_W-1:0] out_median;
  logic [VCNT_W-1:0]       out_valid_count;

  int err_count;
  int pending;
  int medians_checked;
  int burst_left = 0;
  int samples_sent = 0;
  int clears_sent = 0;

  sliding_window_median_filter_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_median      (out_median),
    .out_valid_count (out_valid_count)
  );

  swmf_median_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_median      (out_median),
    .out_valid_count (out_valid_count),
    .err_count       (err_count),
    .pending         (pending),
    .medians_checked (medians_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offers one item; whenever the current burst has run out, it may open a gap first.
  task automatic send_item(input logic req, input logic signed [SMP_W-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_sample   <= smp;
    do @(posedge clk); while (!in_ready);
    if (req == REQ_CLEAR) clears_sent++;
    else samples_sent++;
  endtask

  // Extremes, narrow ranges that give many ties, and the full range.
  function automatic logic signed [SMP_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      1, 2, 3: v = int'($urandom_range(0, 8)) - 4;
      default: v = int'($urandom() & 32'hFFFF);
    endcase
    return v[SMP_W-1:0];
  endfunction

  // The receiver switches between always ready, random, mostly stalled and periodic.
  initial begin : rx_pattern
    int mode;
    int seg_len;
    int period;
    int phase;
    forever begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(20, 200);
      period  = $urandom_range(2, 6);
      for (phase = 0; phase < seg_len; phase++) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= (phase % period == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stuck = 0;
      else stuck++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int n;
    logic req;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Filling from empty with extremes, an even count giving the upper median, then a wrap.
    send_item(REQ_SAMPLE, 16'sh7FFF);
    send_item(REQ_SAMPLE, 16'sh8000);
    send_item(REQ_SAMPLE, 16'sh0000);
    send_item(REQ_SAMPLE, 16'shFFFF);
    send_item(REQ_SAMPLE, 16'sh0001);
    send_item(REQ_SAMPLE, 16'sh5555);
    send_item(REQ_SAMPLE, 16'shAAAA);
    // Clear on a full window, then on an empty one; the sample field must be ignored.
    send_item(REQ_CLEAR, 16'sh7FFF);
    send_item(REQ_CLEAR, 16'shFFFF);
    // Equal samples, then a clear part-way through filling.
    send_item(REQ_SAMPLE, 16'sd100);
    send_item(REQ_SAMPLE, 16'sd100);
    send_item(REQ_SAMPLE, 16'sd100);
    send_item(REQ_SAMPLE, -16'sd100);
    send_item(REQ_CLEAR, 16'sh1234);
    send_item(REQ_SAMPLE, 16'sd5);
    send_item(REQ_SAMPLE, -16'sd5);
    send_item(REQ_SAMPLE, 16'sd5);
    send_item(REQ_SAMPLE, -16'sd5);
    send_item(REQ_SAMPLE, 16'sd5);
    send_item(REQ_SAMPLE, -16'sd5);
    send_item(REQ_SAMPLE, 16'sh8000);
    send_item(REQ_SAMPLE, 16'sh8000);

    for (n = 0; n < N_RANDOM; n++) begin
      req = ($urandom_range(0, 24) == 0) ? REQ_CLEAR : REQ_SAMPLE;
      send_item(req, pick_sample());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d sample items and %0d clear items; %0d medians compared.",
             samples_sent, clears_sent, medians_checked);
    $display("Windows were filled from empty, wrapped, and cleared at random fill levels.");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
